// ----- hw/rtl/sdamt_pkg.sv -----
// Shared types and constants for the static device address map table.
`default_nettype none
package sdamt_pkg;

  localparam int unsigned ENTRIES_DEFAULT = 32;
  localparam int unsigned PAGE_BITS = 12;

  localparam logic [31:0] TOP_ADDRESS_RESET = 32'hFFFF_0000;
  localparam logic [31:0] MIB_MASK = 32'h000F_FFFF;
  localparam logic [31:0] PAGE_ALIGN_MASK = ~((32'd1 << PAGE_BITS) - 32'd1);

  localparam logic [2:0] CMD_ADD = 3'd0;
  localparam logic [2:0] CMD_P2V = 3'd1;
  localparam logic [2:0] CMD_V2P = 3'd2;
  localparam logic [2:0] CMD_QUERY = 3'd3;
  localparam logic [2:0] CMD_SEAL = 3'd4;

  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_FULL = 2'd1;
  localparam logic [1:0] STATUS_SEALED = 2'd2;
  localparam logic [1:0] STATUS_ZERO_LEN = 2'd3;

  typedef struct packed {
    logic [31:0] phys;
    logic [31:0] virt;
    logic [31:0] len;
  } region_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_HIT  = 3'b100
  } state_t;

endpackage
`default_nettype wire

// ----- hw/rtl/static_device_address_map_table_unit.sv -----
// Static device address map table: region store, allocator and range lookup.
// Add, query, seal, undefined commands and empty-table lookups answer at accept;
// a lookup answers once the scan finds its first hit or passes the last entry.
// Throughput: one request at a time; a lookup is bound by the single read port
// of the region memory, which the scan walks one entry per cycle.
// Reset (rst, synchronous): empty table, unsealed, top_address = 0xFFFF0000.
// Region memory contents are not cleared; only entries below the count are read.
`default_nettype none
module static_device_address_map_table_unit #(
  parameter int unsigned ENTRIES = sdamt_pkg::ENTRIES_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write_enable,
  input  wire logic [31:0] cfg_write_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  command,
  input  wire logic [31:0] address,
  input  wire logic [31:0] length,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      result_address,
  output logic             found,
  output logic [1:0]       status
);

  localparam int unsigned IDX_W = $clog2(ENTRIES);
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(ENTRIES - 1);

  // Region store: one entry per region, one write and one read port.
  sdamt_pkg::region_t mem [ENTRIES];
  sdamt_pkg::region_t rd_data;

  sdamt_pkg::state_t state;

  logic [31:0]      top_address;
  logic [31:0]      next_virt;
  logic [IDX_W-1:0] region_count;
  logic             sealed;

  // Latched lookup request.
  logic             is_v2p;
  logic [31:0]      addr_r;
  logic [32:0]      q_end;

  // Scan issue and read pipeline.
  logic [IDX_W-1:0] iss_idx;
  logic             issued_all;
  logic             rd_vld;
  logic             rd_last;

  // Matching entry, held for the translate step.
  logic [31:0]      hit_key;
  logic [31:0]      hit_other;

  logic             in_fire;
  logic             out_free;
  logic             wr_en;
  logic [31:0]      alloc_raw;
  logic [31:0]      alloc_virt;
  logic             mib_aligned;
  logic [31:0]      key;
  logic [31:0]      other;
  logic [32:0]      r_end;
  logic             match;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == sdamt_pkg::ST_IDLE) && out_free;
  assign in_fire  = in_valid && in_ready;

  // Allocation: step down by the length, then round to 1 MiB or to a page.
  assign alloc_raw   = next_virt - length;
  assign mib_aligned = ((address & sdamt_pkg::MIB_MASK) == 32'd0) &&
                       ((length & sdamt_pkg::MIB_MASK) == 32'd0);
  assign alloc_virt  = mib_aligned ? (alloc_raw & ~sdamt_pkg::MIB_MASK)
                                   : (alloc_raw & sdamt_pkg::PAGE_ALIGN_MASK);

  // Commit the add only when none of the rejects apply.
  assign wr_en = in_fire && (command == sdamt_pkg::CMD_ADD) && !sealed &&
                 (region_count != LAST_SLOT) && (length != 32'd0);

  // Range compare at 33 bits so neither end wraps.
  assign key   = is_v2p ? rd_data.virt : rd_data.phys;
  assign other = is_v2p ? rd_data.phys : rd_data.virt;
  assign r_end = {1'b0, key} + {1'b0, rd_data.len};
  assign match = (addr_r >= key) && (q_end <= r_end);

  // Memory write at accept, registered read every cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[region_count] <= '{phys: address, virt: alloc_virt, len: length};
    end
    rd_data <= mem[iss_idx];
  end

  // Configuration register and allocation state.
  always_ff @(posedge clk) begin
    if (rst) begin
      top_address  <= sdamt_pkg::TOP_ADDRESS_RESET;
      next_virt    <= sdamt_pkg::TOP_ADDRESS_RESET;
      region_count <= '0;
      sealed       <= 1'b0;
    end else begin
      if (cfg_write_enable) begin
        top_address <= cfg_write_data;
        // An empty table allocates from the new top.
        if (region_count == '0) begin
          next_virt <= cfg_write_data;
        end
      end
      if (wr_en) begin
        next_virt    <= alloc_virt;
        region_count <= region_count + 1'b1;
      end
      if (in_fire && (command == sdamt_pkg::CMD_SEAL)) begin
        sealed <= 1'b1;
      end
    end
  end

  // Control: accept, scan, translate, and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= sdamt_pkg::ST_IDLE;
      out_valid  <= 1'b0;
      rd_vld     <= 1'b0;
      rd_last    <= 1'b0;
      issued_all <= 1'b0;
      iss_idx    <= '0;
    end else begin
      unique case (state)
        sdamt_pkg::ST_IDLE: begin
          if (in_fire) begin
            is_v2p  <= (command == sdamt_pkg::CMD_V2P);
            addr_r  <= address;
            q_end   <= {1'b0, address} + {1'b0, length};
            iss_idx <= '0;
            rd_vld  <= 1'b0;
            issued_all <= 1'b0;
            found   <= 1'b0;
            if (((command == sdamt_pkg::CMD_P2V) || (command == sdamt_pkg::CMD_V2P)) &&
                (region_count != '0)) begin
              // Preload a miss; the scan answers later.
              result_address <= '0;
              status    <= sdamt_pkg::STATUS_OK;
              out_valid <= 1'b0;
              state     <= sdamt_pkg::ST_SCAN;
            end else begin
              // Answer at once; an empty-table lookup is a plain miss.
              out_valid <= 1'b1;
              if (command == sdamt_pkg::CMD_ADD) begin
                priority if (sealed) begin
                  result_address <= '0;
                  status <= sdamt_pkg::STATUS_SEALED;
                end else if (region_count == LAST_SLOT) begin
                  result_address <= '0;
                  status <= sdamt_pkg::STATUS_FULL;
                end else if (length == 32'd0) begin
                  result_address <= '0;
                  status <= sdamt_pkg::STATUS_ZERO_LEN;
                end else begin
                  result_address <= alloc_virt;
                  status <= sdamt_pkg::STATUS_OK;
                end
              end else if (command == sdamt_pkg::CMD_QUERY) begin
                result_address <= (region_count != '0) ? next_virt : top_address;
                status <= sdamt_pkg::STATUS_OK;
              end else begin
                result_address <= '0;
                status <= sdamt_pkg::STATUS_OK;
              end
            end
          end else if (out_ready) begin
            // Drop the answer once it is taken.
            out_valid <= 1'b0;
          end
        end
        sdamt_pkg::ST_SCAN: begin
          // Check the entry read last cycle; the first hit wins. Otherwise
          // issue one read per cycle until the last stored entry.
          priority if (rd_vld && match) begin
            hit_key   <= key;
            hit_other <= other;
            rd_vld    <= 1'b0;
            state     <= sdamt_pkg::ST_HIT;
          end else if (rd_vld && rd_last) begin
            rd_vld    <= 1'b0;
            out_valid <= 1'b1;
            state     <= sdamt_pkg::ST_IDLE;
          end else if (!issued_all) begin
            rd_vld     <= 1'b1;
            rd_last    <= (iss_idx == region_count - 1'b1);
            issued_all <= (iss_idx == region_count - 1'b1);
            iss_idx    <= iss_idx + 1'b1;
          end else begin
            rd_vld <= 1'b0;
          end
        end
        sdamt_pkg::ST_HIT: begin
          result_address <= hit_other + (addr_r - hit_key);
          found     <= 1'b1;
          out_valid <= 1'b1;
          state     <= sdamt_pkg::ST_IDLE;
        end
        default: begin
          state <= sdamt_pkg::ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // The output register is empty for the whole of a lookup.
  a_out_empty_busy: assert property (@(posedge clk) disable iff (rst)
    (state != sdamt_pkg::ST_IDLE) |-> !out_valid)
    else $error("output register occupied during a lookup");

  // A sealed table takes no more regions.
  a_sealed_no_add: assert property (@(posedge clk) disable iff (rst)
    (in_fire && (command == sdamt_pkg::CMD_ADD) && sealed) |=> $stable(region_count))
    else $error("region added to a sealed table");

  // The count never goes past the last slot index.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    region_count <= LAST_SLOT)
    else $error("region count past the last usable slot");
`endif

endmodule
`default_nettype wire

// ----- bench/sdamt_checker.sv -----
// Checker for the device address map table: predicts every answer and compares it.
`timescale 1ns / 1ps
module sdamt_checker #(
  parameter int unsigned ENTRIES = sdamt_pkg::ENTRIES_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write_enable,
  input  wire logic [31:0] cfg_write_data,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [2:0]  command,
  input  wire logic [31:0] address,
  input  wire logic [31:0] length,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [31:0] result_address,
  input  wire logic        found,
  input  wire logic [1:0]  status,
  output int               outstanding,
  output int               fail_count
);

  typedef struct packed {
    logic [31:0] addr;
    logic        hit;
    logic [1:0]  code;
  } map_answer_t;

  logic [31:0] top_reg;
  logic [31:0] next_virt;
  logic        is_sealed;
  int          stored;
  logic [31:0] map_phys [ENTRIES];
  logic [31:0] map_virt [ENTRIES];
  logic [31:0] map_len  [ENTRIES];

  map_answer_t pending_answers [$];

  initial begin
    outstanding = 0;
    fail_count = 0;
  end

  // First stored region that covers [addr, addr+len]; ends compared at 33 bits.
  function automatic int find_region(input bit use_virt, input logic [31:0] addr,
                                     input logic [31:0] len);
    logic [32:0] span_end;
    logic [32:0] region_end;
    logic [31:0] key;
    span_end = {1'b0, addr} + {1'b0, len};
    for (int i = 0; i < stored; i++) begin
      key = use_virt ? map_virt[i] : map_phys[i];
      region_end = {1'b0, key} + {1'b0, map_len[i]};
      if (addr >= key && span_end <= region_end) return i;
    end
    return -1;
  endfunction

  function automatic map_answer_t predict_mapping(input logic [2:0] cmd,
                                                  input logic [31:0] addr,
                                                  input logic [31:0] len);
    map_answer_t ans;
    logic [31:0] base;
    int k;
    ans = '0;
    case (cmd)
      sdamt_pkg::CMD_ADD: begin
        if (is_sealed) begin
          ans.code = sdamt_pkg::STATUS_SEALED;
        end else if (stored >= ENTRIES - 1) begin
          ans.code = sdamt_pkg::STATUS_FULL;
        end else if (len == 32'd0) begin
          ans.code = sdamt_pkg::STATUS_ZERO_LEN;
        end else begin
          base = next_virt - len;
          if ((addr & sdamt_pkg::MIB_MASK) == 32'd0 && (len & sdamt_pkg::MIB_MASK) == 32'd0)
            base &= ~sdamt_pkg::MIB_MASK;
          else base &= sdamt_pkg::PAGE_ALIGN_MASK;
          next_virt = base;
          map_phys[stored] = addr;
          map_virt[stored] = base;
          map_len[stored] = len;
          stored++;
          ans.addr = base;
        end
      end
      sdamt_pkg::CMD_P2V: begin
        k = find_region(1'b0, addr, len);
        if (k >= 0) begin
          ans.hit = 1'b1;
          ans.addr = map_virt[k] + (addr - map_phys[k]);
        end
      end
      sdamt_pkg::CMD_V2P: begin
        k = find_region(1'b1, addr, len);
        if (k >= 0) begin
          ans.hit = 1'b1;
          ans.addr = map_phys[k] + (addr - map_virt[k]);
        end
      end
      sdamt_pkg::CMD_QUERY: ans.addr = (stored > 0) ? next_virt : top_reg;
      sdamt_pkg::CMD_SEAL: is_sealed = 1'b1;
      default: ;
    endcase
    return ans;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    map_answer_t want;
    if (rst) begin
      top_reg = sdamt_pkg::TOP_ADDRESS_RESET;
      next_virt = sdamt_pkg::TOP_ADDRESS_RESET;
      is_sealed = 1'b0;
      stored = 0;
      pending_answers.delete();
    end else begin
      if (cfg_write_enable) begin
        top_reg = cfg_write_data;
        if (stored == 0) next_virt = cfg_write_data;
      end
      if (in_valid && in_ready) pending_answers.push_back(predict_mapping(command, address, length));
      if (out_valid && out_ready) begin
        if (pending_answers.size() == 0) begin
          $display("%0t: result with no request pending: expected none, actual %h/%b/%h",
                   $time, result_address, found, status);
          fail_count++;
        end else begin
          want = pending_answers.pop_front();
          check_field("result_address", want.addr, result_address);
          check_field("found", {31'd0, want.hit}, {31'd0, found});
          check_field("status", {30'd0, want.code}, {30'd0, status});
        end
      end
    end
    outstanding <= pending_answers.size();
  end

endmodule

// ----- bench/tb_static_device_address_map_table_unit.sv -----
// Top of the address map table testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_static_device_address_map_table_unit;

  // Commands outside the defined set; the block must answer them with zeros.
  localparam logic [2:0] CMD_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] CMD_UNUSED_LAST = 3'd7;
  // A lookup scans at most 31 regions; the limit is many times the slowest run.
  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 40;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] addr;
    logic [31:0] len;
  } sent_req_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write_enable = 1'b0;
  logic [31:0] cfg_write_data = 32'd0;
  logic        in_valid = 1'b0;
  logic [2:0]  command = sdamt_pkg::CMD_ADD;
  logic [31:0] address = 32'd0;
  logic [31:0] length = 32'd0;
  logic        out_ready = 1'b0;
  wire logic        in_ready;
  wire logic        out_valid;
  wire logic [31:0] result_address;
  wire logic        found;
  wire logic [1:0]  status;

  int outstanding;
  int fail_count;
  int cycle_count = 0;
  bit steady = 1'b0;

  // Stimulus bookkeeping: regions the block has mapped, taken from its answers,
  // so lookups can be aimed at real ranges.
  sent_req_t   request_log [$];
  logic [31:0] known_phys [$];
  logic [31:0] known_virt [$];
  logic [31:0] known_len [$];
  int adds_refused = 0;
  int lookups = 0;
  int lookup_hits = 0;
  int queries = 0;
  int seals = 0;
  int unused_cmds = 0;
  int top_writes = 0;

  static_device_address_map_table_unit dut (
    .clk(clk),
    .rst(rst),
    .cfg_write_enable(cfg_write_enable),
    .cfg_write_data(cfg_write_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .command(command),
    .address(address),
    .length(length),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .result_address(result_address),
    .found(found),
    .status(status)
  );

  sdamt_checker chk (
    .clk(clk),
    .rst(rst),
    .cfg_write_enable(cfg_write_enable),
    .cfg_write_data(cfg_write_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .command(command),
    .address(address),
    .length(length),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .result_address(result_address),
    .found(found),
    .status(status),
    .outstanding(outstanding),
    .fail_count(fail_count)
  );

  always #10 clk = ~clk;

  // Stall the result side in about 36 percent of cycles, except in the steady stretch.
  always @(posedge clk) begin
    out_ready <= !rst && (steady || $urandom_range(99) >= 36);
  end

  // Hard stop if the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: run exceeded %0d cycles, %0d answers outstanding",
               $time, CYCLE_LIMIT, outstanding);
      $display("Verification failed");
      $finish;
    end
  end

  // Pair each answer with its request to learn the mapped regions and tally coverage.
  always @(posedge clk) begin : track
    sent_req_t done;
    if (!rst) begin
      if (in_valid && in_ready) request_log.push_back({command, address, length});
      if (out_valid && out_ready && request_log.size() > 0) begin
        done = request_log.pop_front();
        case (done.cmd)
          sdamt_pkg::CMD_ADD: begin
            if (status == sdamt_pkg::STATUS_OK) begin
              known_phys.push_back(done.addr);
              known_virt.push_back(result_address);
              known_len.push_back(done.len);
            end else begin
              adds_refused++;
            end
          end
          sdamt_pkg::CMD_P2V, sdamt_pkg::CMD_V2P: begin
            lookups++;
            if (found) lookup_hits++;
          end
          sdamt_pkg::CMD_QUERY: queries++;
          sdamt_pkg::CMD_SEAL: seals++;
          default: unused_cmds++;
        endcase
      end
    end
  end

  // Present one request and hold it until the block takes it. Valid stays high
  // on return so a back-to-back request needs no second assignment.
  task automatic issue(input logic [2:0] cmd, input logic [31:0] addr,
                       input logic [31:0] len);
    while (!steady && $urandom_range(99) < 36) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    address <= addr;
    length <= len;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Drop valid and wait until every answer has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Write the top address; only call with the block idle.
  task automatic set_top(input logic [31:0] value);
    cfg_write_data <= value;
    cfg_write_enable <= 1'b1;
    @(posedge clk);
    cfg_write_enable <= 1'b0;
    @(posedge clk);
    top_writes++;
  endtask

  // Add a region: many small ones up to 128 KiB, some 1 MiB aligned, a few huge or empty.
  task automatic issue_add();
    int unsigned pick;
    logic [31:0] phys;
    logic [31:0] len;
    pick = $urandom_range(19);
    phys = $urandom;
    if (pick < 6) begin
      phys &= ~sdamt_pkg::MIB_MASK;
      len = $urandom_range(16, 1);
      len = len << 20;
    end else if (pick < 15) begin
      len = $urandom_range(32'h0002_0000, 1);
    end else if (pick < 17) begin
      phys &= ~sdamt_pkg::MIB_MASK;
      len = $urandom;
    end else if (pick < 19) begin
      len = $urandom;
    end else begin
      len = 32'd0;
    end
    issue(sdamt_pkg::CMD_ADD, phys, len);
  endtask

  // Aim a lookup at a known region: exact, inside, end byte, overrun, just below, or noise.
  task automatic issue_lookup(input bit use_virt);
    int unsigned pick;
    logic [31:0] base;
    logic [31:0] span;
    logic [31:0] off;
    logic [2:0]  cmd;
    cmd = use_virt ? sdamt_pkg::CMD_V2P : sdamt_pkg::CMD_P2V;
    if (known_len.size() == 0) begin
      issue(cmd, $urandom, $urandom);
    end else begin
      pick = $urandom_range(known_len.size() - 1);
      base = use_virt ? known_virt[pick] : known_phys[pick];
      span = known_len[pick];
      off = $urandom_range(span);
      case ($urandom_range(5))
        0: issue(cmd, base, span);
        1: issue(cmd, base + off, $urandom_range(span - off));
        2: issue(cmd, base + span, 32'd0);
        3: issue(cmd, base + off, span - off + 32'd1);
        4: issue(cmd, base - 32'd1, $urandom_range(span));
        default: issue(cmd, $urandom, $urandom_range(255));
      endcase
    end
  endtask

  // One random request; lookups take whatever share adds, queries, undefined commands and seals leave.
  task automatic random_request(input int add_pct, input int seal_pct);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < add_pct) issue_add();
    else if (roll < add_pct + 6) issue(sdamt_pkg::CMD_QUERY, $urandom, $urandom);
    else if (roll < add_pct + 9)
      issue(3'($urandom_range(CMD_UNUSED_LAST, CMD_UNUSED_FIRST)), $urandom, $urandom);
    else if (roll < add_pct + 9 + seal_pct) issue(sdamt_pkg::CMD_SEAL, $urandom, $urandom);
    else issue_lookup(1'($urandom_range(1)));
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty table: reset top address, misses, zero-length add, undefined commands.
    issue(sdamt_pkg::CMD_QUERY, 32'd0, 32'd0);
    issue(sdamt_pkg::CMD_P2V, 32'd0, 32'd0);
    issue(sdamt_pkg::CMD_V2P, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue(sdamt_pkg::CMD_ADD, 32'h4000_0000, 32'd0);
    issue(CMD_UNUSED_FIRST, $urandom, $urandom);
    issue(3'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue(CMD_UNUSED_LAST, $urandom, $urandom);
    drain();

    // With nothing stored, the allocation point follows the register.
    set_top(32'h0000_0000);
    issue(sdamt_pkg::CMD_QUERY, 32'd0, 32'd0);
    drain();
    set_top(32'hFFFF_FFFF);
    issue(sdamt_pkg::CMD_QUERY, 32'd0, 32'd0);
    drain();

    // Low top so the first add wraps below zero; then page rounding, full-range
    // extremes and a region nested in the first one.
    set_top(32'h0020_0000);
    issue(sdamt_pkg::CMD_ADD, 32'h1000_0000, 32'h0030_0000);
    issue(sdamt_pkg::CMD_ADD, 32'h1234_5678, 32'h0000_1801);
    issue(sdamt_pkg::CMD_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue(sdamt_pkg::CMD_ADD, 32'h1010_0000, 32'h0010_0000);
    // First match wins, exact range, zero length at the end byte, one past it.
    issue(sdamt_pkg::CMD_P2V, 32'h1010_0000, 32'h0000_1000);
    issue(sdamt_pkg::CMD_P2V, 32'h1000_0000, 32'h0030_0000);
    issue(sdamt_pkg::CMD_P2V, 32'h1030_0000, 32'd0);
    issue(sdamt_pkg::CMD_P2V, 32'h1030_0000, 32'd1);
    issue(sdamt_pkg::CMD_P2V, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // Ranges that run past 2^32 in virtual space.
    issue(sdamt_pkg::CMD_V2P, 32'hFFF0_0000, 32'h0010_0000);
    issue(sdamt_pkg::CMD_V2P, 32'hFFFF_FFFF, 32'h0020_0000);
    issue(sdamt_pkg::CMD_V2P, 32'd0, 32'd0);
    issue(sdamt_pkg::CMD_QUERY, 32'd0, 32'd0);
    drain();
    // Regions stored now: the write must not move the allocation point.
    set_top(sdamt_pkg::TOP_ADDRESS_RESET);
    issue(sdamt_pkg::CMD_QUERY, 32'd0, 32'd0);

    // Fill the table with random regions mixed with lookups.
    for (int n = 0; n < 300 && known_len.size() < sdamt_pkg::ENTRIES_DEFAULT - 1; n++)
      random_request(45, 0);
    drain();
    set_top(32'h0000_0000);
    issue(sdamt_pkg::CMD_QUERY, 32'd0, 32'd0);
    drain();
    set_top(32'hFFFF_FFFF);

    // Full table: mostly lookups, refused adds, one steady stretch, one mid-phase drain.
    for (int n = 0; n < 600; n++) begin
      steady = (n >= 200 && n < 350);
      if (n == 400) drain();
      random_request(8, 0);
    end
    steady = 1'b0;
    drain();
    set_top($urandom);

    // Sealed table: adds refused as sealed, lookups still served, repeat seals.
    issue(sdamt_pkg::CMD_SEAL, $urandom, $urandom);
    for (int n = 0; n < 600; n++) random_request(12, 2);
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d mapped regions, %0d refused adds, %0d lookups with %0d hits,",
             known_len.size(), adds_refused, lookups, lookup_hits);
    $display("%0d queries, %0d seals, %0d undefined commands, %0d top address writes.",
             queries, seals, unused_cmds, top_writes);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
